// ===== design/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/kmbd_pkg.sv =====
package kmbd_pkg;
  localparam int unsigned TabLen = 115;
  localparam logic [7:0] PktStart = 8'hF8;
  localparam logic [7:0] ScCaps = 8'h3A;
  localparam logic [7:0] ScLShift = 8'h2A;
  localparam logic [7:0] ScRShift = 8'h36;
  localparam logic [7:0] ScLBreak = 8'hAA;
  localparam logic [7:0] ScRBreak = 8'hB6;

  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_HDR = 2'd1,
    KIND_DX  = 2'd2,
    KIND_DY  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cls_item_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_CAPS = 2'd1,
    MODE_LSH  = 2'd2,
    MODE_RSH  = 2'd3
  } key_mode_t;

  typedef enum logic [1:0] {
    TAB_PLAIN = 2'd0,
    TAB_CAPS  = 2'd1,
    TAB_SHIFT = 2'd2
  } tab_sel_t;

  localparam logic [7:0] TAB_P [TabLen] = '{
    8'h00,8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2d,8'h3d,
    8'h08,8'h09,8'h71,8'h77,8'h65,8'h72,8'h74,8'h79,8'h75,8'h69,8'h6f,8'h70,8'h5b,8'h5d,
    8'h0d,8'h00,8'h61,8'h73,8'h64,8'h66,8'h67,8'h68,8'h6a,8'h6b,8'h6c,8'h3b,8'h27,8'h60,
    8'h00,8'h5c,8'h7a,8'h78,8'h63,8'h76,8'h62,8'h6e,8'h6d,8'h2c,8'h2e,8'h2f,8'h00,8'h00,
    8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h2d,8'h00,8'h00,8'h00,8'h2b,8'h00,8'h00,8'h00,8'h00,8'h7f,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h28,8'h29,8'h2f,8'h2a,8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,
    8'h30,8'h2e,8'h0d};

  localparam logic [7:0] TAB_C [TabLen] = '{
    8'h00,8'h1b,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,8'h2d,8'h3d,
    8'h08,8'h09,8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4f,8'h50,8'h5b,8'h5d,
    8'h0d,8'h00,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,8'h4a,8'h4b,8'h4c,8'h3b,8'h27,8'h60,
    8'h00,8'h5c,8'h5a,8'h58,8'h43,8'h56,8'h42,8'h4e,8'h4d,8'h2c,8'h2e,8'h2f,8'h00,8'h00,
    8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h2d,8'h00,8'h00,8'h00,8'h2b,8'h00,8'h00,8'h00,8'h00,8'h7f,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h28,8'h29,8'h2f,8'h2a,8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,
    8'h30,8'h2e,8'h0d};

  localparam logic [7:0] TAB_S [TabLen] = '{
    8'h00,8'h1b,8'h21,8'h40,8'h23,8'h24,8'h25,8'h5e,8'h26,8'h2a,8'h28,8'h29,8'h5f,8'h2b,
    8'h08,8'h09,8'h51,8'h57,8'h45,8'h52,8'h54,8'h59,8'h55,8'h49,8'h4f,8'h50,8'h7b,8'h7d,
    8'h0d,8'h00,8'h41,8'h53,8'h44,8'h46,8'h47,8'h48,8'h4a,8'h4b,8'h4c,8'h3a,8'h22,8'h7e,
    8'h00,8'h7c,8'h5a,8'h58,8'h43,8'h56,8'h42,8'h4e,8'h4d,8'h3c,8'h3e,8'h3f,8'h00,8'h00,
    8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h37,8'h38,8'h00,8'h2d,8'h34,8'h00,8'h36,8'h2b,8'h00,8'h32,8'h00,8'h30,8'h7f,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h28,8'h29,8'h2f,8'h2a,8'h37,8'h38,8'h39,8'h34,8'h35,8'h36,8'h31,8'h32,8'h33,
    8'h30,8'h2e,8'h0d};

  function automatic logic [6:0] look(input tab_sel_t sel, input logic [7:0] code);
    logic [7:0] v;
    v = 8'd0;
    if (code < 8'(TabLen)) begin
      case (sel)
        TAB_PLAIN: v = TAB_P[code[6:0]];
        TAB_CAPS:  v = TAB_C[code[6:0]];
        TAB_SHIFT: v = TAB_S[code[6:0]];
        default:   v = 8'd0;
      endcase
    end
    return v[6:0];
  endfunction
endpackage

// ===== design/kmbd_front.sv =====
module kmbd_front import kmbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       ok,
  output cls_item_t  item,
  output logic       item_valid
);
  // packet framing: 0 idle, 1 expect x, 2 expect y
  logic [1:0] packet_phase;

  always_comb begin
    item.data = in_byte;
    case (packet_phase)
      2'd1:    item.kind = KIND_DX;
      2'd2:    item.kind = KIND_DY;
      default: item.kind = (in_byte >= PktStart) ? KIND_HDR : KIND_KEY;
    endcase
  end
  assign item_valid = push & ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase <= 2'd0;
    end else if (item_valid) begin
      case (item.kind)
        KIND_HDR: packet_phase <= 2'd1;
        KIND_DX:  packet_phase <= 2'd2;
        default:  packet_phase <= 2'd0;
      endcase
    end
  end
endmodule

// ===== design/kmbd_queue.sv =====
module kmbd_queue import kmbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  cls_item_t wdata,
  output logic      full,
  input  logic      rd,
  output cls_item_t rdata,
  output logic      empty
);
  cls_item_t  mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ===== design/kmbd_back.sv =====
module kmbd_back import kmbd_pkg::*; #(
  parameter logic [9:0] HOME_X = 10'd320,
  parameter logic [9:0] HOME_Y = 10'd200
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  cls_item_t  item,
  output logic       in_take,
  input  logic       keys_enabled,
  input  logic       pointer_enabled,
  input  logic [9:0] limit_x,
  input  logic [9:0] limit_y,
  output logic       empty,
  input  logic       pop,
  output logic       char_valid,
  output logic [6:0] char_code,
  output logic [9:0] pointer_x,
  output logic [9:0] pointer_y,
  output logic [7:0] button_byte
);
  key_mode_t  key_mode, key_mode_next;
  logic [9:0] pos_x, pos_y;
  logic [7:0] button_latch;
  logic [6:0] ch;
  logic [9:0] mv_pos, mv_lim, mv_res;
  logic signed [11:0] sum;
  logic       out_full;

  assign empty   = ~out_full;
  assign in_take = in_valid & (~out_full | pop);

  always_comb begin
    key_mode_next = key_mode;
    ch = 7'd0;
    if (item.kind == KIND_KEY && keys_enabled &&
        !(item.data[7] && item.data != ScLBreak && item.data != ScRBreak)) begin
      case (key_mode)
        MODE_NONE: begin
          if (item.data == ScCaps) key_mode_next = MODE_CAPS;
          else if (item.data == ScLShift) key_mode_next = MODE_LSH;
          else if (item.data == ScRShift) key_mode_next = MODE_RSH;
          else ch = look(TAB_PLAIN, item.data);
        end
        MODE_CAPS: begin
          if (item.data == ScCaps) key_mode_next = MODE_NONE;
          else ch = look(TAB_CAPS, item.data);
        end
        default: begin
          if ((key_mode == MODE_LSH && item.data == ScLBreak) ||
              (key_mode == MODE_RSH && item.data == ScRBreak)) key_mode_next = MODE_NONE;
          else if (item.data == ScCaps) key_mode_next = MODE_CAPS;
          else ch = look(TAB_SHIFT, item.data);
        end
      endcase
    end
  end

  // shared clamp unit for both axes
  always_comb begin
    mv_pos = (item.kind == KIND_DX) ? pos_x : pos_y;
    mv_lim = (item.kind == KIND_DX) ? limit_x : limit_y;
    sum = $signed({2'b00, mv_pos}) + 12'($signed(item.data));
    if (sum < 0) mv_res = 10'd0;
    else if (sum > $signed({2'b00, mv_lim})) mv_res = mv_lim;
    else mv_res = sum[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode <= MODE_NONE;
      pos_x <= HOME_X;
      pos_y <= HOME_Y;
      button_latch <= 8'd0;
      out_full <= 1'b0;
    end else begin
      if (in_take) begin
        key_mode <= key_mode_next;
        if (pointer_enabled) begin
          if (item.kind == KIND_HDR) button_latch <= item.data;
          if (item.kind == KIND_DX) pos_x <= mv_res;
          if (item.kind == KIND_DY) pos_y <= mv_res;
        end
        out_full <= 1'b1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  // result register, built from the state as it stands after this item
  always_ff @(posedge clk) begin
    if (in_take) begin
      char_valid  <= ch != 7'd0;
      char_code   <= ch;
      pointer_x   <= (pointer_enabled && item.kind == KIND_DX) ? mv_res : pos_x;
      pointer_y   <= (pointer_enabled && item.kind == KIND_DY) ? mv_res : pos_y;
      button_byte <= (pointer_enabled && item.kind == KIND_HDR) ? item.data : button_latch;
    end
  end
endmodule

// ===== design/keyboard_mouse_byte_decoder_top.sv =====
// keyboard/mouse byte decoder
// input channel: push with in_byte, taken when full is low; one byte per cycle
// result channel: one result item per input byte, shown while empty is low,
// taken with pop; results keep input order
// path: an accepted byte is written into the classifier queue and then into the
// back end's result register before it reaches the result ports
// throughput: one byte per cycle while the receiver keeps popping, set by the
// single update of the key and pointer state in the back end each cycle
// the front end frames mouse packets and classifies bytes; a two-entry queue
// separates it from the back end that runs the shift/caps machine, the
// rom lookup and the clamped position update
// when the receiver stalls the result register holds, the queue fills and
// full rises after two more bytes; nothing is dropped
// reset (synchronous, rst high) empties the queue and result register,
// returns pointer to home, clears the button byte and key mode, disables
// keys and pointer and sets the limits to 639 by 399
// configuration: apb writes to 0x0 keys enable, 0x4 pointer enable,
// 0x8 limit x, 0xc limit y; write only while idle
module keyboard_mouse_byte_decoder_top import kmbd_pkg::*; #(
  parameter logic [9:0] HOME_X = 10'd320,
  parameter logic [9:0] HOME_Y = 10'd200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic        char_valid,
  output logic [6:0]  char_code,
  output logic [9:0]  pointer_x,
  output logic [9:0]  pointer_y,
  output logic [7:0]  button_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  // register word indices, decoded from paddr[3:2]
  localparam logic [1:0] RegKeys = 2'd0;
  localparam logic [1:0] RegPtr  = 2'd1;
  localparam logic [1:0] RegLimX = 2'd2;
  localparam logic [1:0] RegLimY = 2'd3;

  logic       keys_enabled, pointer_enabled;
  logic [9:0] limit_x, limit_y;
  logic       cfg_wr;

  cls_item_t  f_item, q_item;
  logic       f_valid, q_full, q_empty, q_take;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      keys_enabled <= 1'b0;
      pointer_enabled <= 1'b0;
      limit_x <= 10'd639;
      limit_y <= 10'd399;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegKeys: keys_enabled <= pwdata[0];
        RegPtr:  pointer_enabled <= pwdata[0];
        RegLimX: limit_x <= pwdata[9:0];
        RegLimY: limit_y <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegKeys: prdata = {31'd0, keys_enabled};
      RegPtr:  prdata = {31'd0, pointer_enabled};
      RegLimX: prdata = {22'd0, limit_x};
      RegLimY: prdata = {22'd0, limit_y};
      default: prdata = 32'd0;
    endcase
  end

  assign full = q_full;

  kmbd_front u_front (
    .clk(clk), .rst(rst), .push(push), .in_byte(in_byte), .ok(~q_full),
    .item(f_item), .item_valid(f_valid)
  );

  kmbd_queue u_queue (
    .clk(clk), .rst(rst), .wr(f_valid), .wdata(f_item), .full(q_full),
    .rd(q_take), .rdata(q_item), .empty(q_empty)
  );

  kmbd_back #(.HOME_X(HOME_X), .HOME_Y(HOME_Y)) u_back (
    .clk(clk), .rst(rst), .in_valid(~q_empty), .item(q_item), .in_take(q_take),
    .keys_enabled(keys_enabled), .pointer_enabled(pointer_enabled),
    .limit_x(limit_x), .limit_y(limit_y),
    .empty(empty), .pop(pop),
    .char_valid(char_valid), .char_code(char_code),
    .pointer_x(pointer_x), .pointer_y(pointer_y), .button_byte(button_byte)
  );
endmodule

// ===== design/kmbd_checker.sv =====
`include "assert_macros.svh"
module kmbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       char_valid,
  input logic [6:0] char_code
);
  `CHK_IMPL(a_char_flag, clk, rst, !empty, char_valid == (char_code != 7'd0), "char flag mismatch")
  `CHK_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(char_code), "result lost under stall")
  `CHK_NEXT(a_fill, clk, rst, full && !pop, full && !empty, "queue drained under stall")
  `CHK_NEXT(a_reset, clk, 1'b0, rst, empty && !full, "not empty after reset")
endmodule

bind keyboard_mouse_byte_decoder_top kmbd_checker u_chk (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .char_valid(char_valid), .char_code(char_code)
);
